@@ hdl/huffman_tree_bit_decoder_defines.svh @@
// Assertion macros for the huffman tree bit decoder checker.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef HUFFMAN_TREE_BIT_DECODER_DEFINES_SVH
`define HUFFMAN_TREE_BIT_DECODER_DEFINES_SVH

// same-cycle implication
`define HTD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HTD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/htd_pkg.sv @@
// Shared constants, codes and types of the huffman tree bit decoder.
// No dependencies.
package htd_pkg;

  localparam int NODE_DEPTH      = 512;
  localparam int MAX_CODE_LENGTH = 31;
  localparam int NODE_AW         = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
  localparam int NODE_CW         = $clog2(NODE_DEPTH + 1);
  localparam int SYM_W           = 9;
  localparam int CODE_W          = 31;
  localparam int LEN_W           = 5;
  localparam int BYTE_W          = 8;
  localparam int REM_W           = 5;
  localparam int OUT_SYM_W       = 8;
  localparam int KIND_W          = 2;
  localparam int STAT_W          = 3;

  localparam logic [KIND_W-1:0] KIND_SYMBOL  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STR_END = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_LEN = 3'd1;
  localparam logic [STAT_W-1:0] STAT_DUP     = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FULL    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_INVALID = 3'd4;

  typedef enum logic [1:0] {
    ES_IDLE,
    ES_INS,
    ES_DEC,
    ES_FIN
  } eng_state_t;

  typedef struct packed {
    logic [NODE_AW-1:0] left;
    logic [NODE_AW-1:0] right;
    logic               leaf;
    logic [SYM_W-1:0]   sym;
  } node_ent_t;

  localparam int NODE_W = $bits(node_ent_t);

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [OUT_SYM_W-1:0] sym;
    logic [STAT_W-1:0]    status;
    logic                 last;
  } res_t;

endpackage

@@ hdl/htd_if.sv @@
// Request channel interfaces: input items and result items.
// Depends on htd_pkg.
interface htd_in_if import htd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [SYM_W-1:0]   symbol;
  logic [CODE_W-1:0]  code_bits;
  logic [LEN_W-1:0]   code_length;
  logic [BYTE_W-1:0]  data_byte;
  logic               end_of_string;

  modport source (output valid, func, symbol, code_bits, code_length, data_byte,
                  end_of_string, input ready);
  modport sink (input valid, func, symbol, code_bits, code_length, data_byte,
                end_of_string, output ready);
endinterface

interface htd_out_if import htd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [OUT_SYM_W-1:0] decoded_symbol;
  logic [STAT_W-1:0]    status;
  logic                 last_of_run;

  modport source (output valid, kind, decoded_symbol, status, last_of_run, input ready);
  modport sink (input valid, kind, decoded_symbol, status, last_of_run, output ready);
endinterface

@@ hdl/htd_node_mem.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module htd_node_mem #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/htd_out_reg.sv @@
// Output register stage for result requests.
// Depends on htd_pkg.
module htd_out_reg import htd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t res,
  output logic can_push,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic valid_r;
  res_t data_r;

  assign can_push  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= res;
    end
  end

endmodule

@@ hdl/htd_engine.sv @@
// Tree walk engine: insert and decode sequencer around the node memory.
// Depends on htd_pkg; drives htd_node_mem and htd_out_reg.
module htd_engine import htd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic [SYM_W-1:0]   in_symbol,
  input  logic [CODE_W-1:0]  in_code_bits,
  input  logic [LEN_W-1:0]   in_code_length,
  input  logic [BYTE_W-1:0]  in_data_byte,
  input  logic               in_end_of_string,
  input  logic               res_ready,
  output logic               res_push,
  output res_t               res,
  output logic               mem_we,
  output logic [NODE_AW-1:0] mem_waddr,
  output node_ent_t          mem_wdata,
  output logic               mem_re,
  output logic [NODE_AW-1:0] mem_raddr,
  input  node_ent_t          mem_rdata
);

  eng_state_t         state_r, state_nxt;
  logic [SYM_W-1:0]   sym_r, sym_nxt;
  logic [CODE_W-1:0]  code_r, code_nxt;
  logic [BYTE_W-1:0]  byte_r, byte_nxt;
  logic               eos_r, eos_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt, rem_m1;
  logic [NODE_AW-1:0] ins_node_r, ins_node_nxt;
  logic [NODE_AW-1:0] cur_node_r, cur_node_nxt;
  logic               fresh_r, fresh_nxt;
  logic               chk_r, chk_nxt;
  logic               padding_r, padding_nxt;
  logic               error_r, error_nxt;
  logic [NODE_CW-1:0] used_r, used_nxt;
  logic               pend_v_r, pend_v_nxt;
  res_t               pend_r, pend_nxt;
  logic               rd_root_r;
  logic               root_init_r;

  node_ent_t          e_mem, e, alloc_ent, leaf_ent;
  logic               ins_bit, dec_bit, full, err_now;
  logic               leaf_hit, dec_done, ins_end, res_new, go;
  logic [NODE_AW-1:0] ins_slot, dec_next;
  res_t               new_res;

  // root entry reads as empty until first written after reset
  always_comb begin
    e_mem = (rd_root_r && !root_init_r) ? '0 : mem_rdata;
    e     = (state_r == ES_INS && fresh_r) ? '0 : e_mem;
  end

  assign rem_m1   = rem_r - REM_W'(1);
  assign ins_bit  = code_r[rem_m1];
  assign dec_bit  = byte_r[rem_m1[2:0]];
  assign ins_slot = ins_bit ? e.right : e.left;
  assign dec_next = dec_bit ? e.right : e.left;
  assign full     = (used_r == NODE_CW'(NODE_DEPTH));
  assign leaf_hit = !padding_r && chk_r && e.leaf;
  assign dec_done = padding_r || (!leaf_hit && rem_r == '0);
  assign ins_end  = (rem_r == '0) || (ins_slot == '0 && full);
  assign res_new  = (state_r == ES_DEC && (leaf_hit || (dec_done && eos_r))) ||
                    (state_r == ES_INS && ins_end);
  assign go       = !(res_new && pend_v_r && !res_ready);
  assign in_ready = (state_r == ES_IDLE);

  // padding check over the bits still left in the byte
  always_comb begin
    err_now = 1'b0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (REM_W'(i) < rem_r && !byte_r[i]) begin
        err_now = 1'b1;
      end
    end
  end

  always_comb begin
    alloc_ent = e;
    if (ins_bit) begin
      alloc_ent.right = used_r[NODE_AW-1:0];
    end else begin
      alloc_ent.left = used_r[NODE_AW-1:0];
    end
    leaf_ent      = e;
    leaf_ent.leaf = 1'b1;
    leaf_ent.sym  = sym_r;
  end

  always_comb begin
    new_res = '0;
    if (state_r == ES_INS) begin
      new_res.kind = KIND_INSERT;
      if (rem_r == '0) begin
        new_res.status = e.leaf ? STAT_DUP : STAT_OK;
      end else begin
        new_res.status = STAT_FULL;
      end
    end else if (leaf_hit) begin
      new_res.kind = KIND_SYMBOL;
      new_res.sym  = e.sym[OUT_SYM_W-1:0];
    end else begin
      new_res.kind   = KIND_STR_END;
      new_res.status = (error_r || err_now) ? STAT_INVALID : STAT_OK;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    sym_nxt      = sym_r;
    code_nxt     = code_r;
    byte_nxt     = byte_r;
    eos_nxt      = eos_r;
    rem_nxt      = rem_r;
    ins_node_nxt = ins_node_r;
    cur_node_nxt = cur_node_r;
    fresh_nxt    = fresh_r;
    chk_nxt      = chk_r;
    padding_nxt  = padding_r;
    error_nxt    = error_r;
    used_nxt     = used_r;
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    mem_we       = 1'b0;
    mem_waddr    = ins_node_r;
    mem_wdata    = e;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    res_push     = 1'b0;
    res          = pend_r;
    res.last     = 1'b0;

    case (state_r)
      ES_IDLE: begin
        if (in_valid) begin
          sym_nxt  = in_symbol;
          code_nxt = in_code_bits;
          byte_nxt = in_data_byte;
          eos_nxt  = in_end_of_string;
          if (!in_func) begin
            if (in_code_length == '0 ||
                in_code_length > LEN_W'(MAX_CODE_LENGTH)) begin
              pend_nxt        = '0;
              pend_nxt.kind   = KIND_INSERT;
              pend_nxt.status = STAT_BAD_LEN;
              pend_v_nxt      = 1'b1;
              state_nxt       = ES_FIN;
            end else begin
              mem_re       = 1'b1;
              mem_raddr    = '0;
              ins_node_nxt = '0;
              fresh_nxt    = 1'b0;
              rem_nxt      = REM_W'(in_code_length);
              state_nxt    = ES_INS;
            end
          end else begin
            rem_nxt = REM_W'(BYTE_W);
            chk_nxt = 1'b0;
            if (!padding_r) begin
              mem_re    = 1'b1;
              mem_raddr = cur_node_r;
            end
            state_nxt = ES_DEC;
          end
        end
      end

      ES_INS: begin
        if (go) begin
          if (rem_r == '0) begin
            if (!e.leaf) begin
              mem_we    = 1'b1;
              mem_wdata = leaf_ent;
            end
            state_nxt = ES_FIN;
          end else if (ins_slot != '0) begin
            mem_re       = 1'b1;
            mem_raddr    = ins_slot;
            ins_node_nxt = ins_slot;
            fresh_nxt    = 1'b0;
            rem_nxt      = rem_m1;
          end else if (full) begin
            // a node allocated by this insert still has to be written empty
            if (fresh_r) begin
              mem_we    = 1'b1;
              mem_wdata = '0;
            end
            state_nxt = ES_FIN;
          end else begin
            mem_we       = 1'b1;
            mem_wdata    = alloc_ent;
            ins_node_nxt = used_r[NODE_AW-1:0];
            fresh_nxt    = 1'b1;
            used_nxt     = used_r + NODE_CW'(1);
            rem_nxt      = rem_m1;
          end
        end
      end

      ES_DEC: begin
        if (go) begin
          if (dec_done) begin
            if (eos_r) begin
              cur_node_nxt = '0;
              padding_nxt  = 1'b0;
              error_nxt    = 1'b0;
            end else begin
              error_nxt = error_r || err_now;
            end
            chk_nxt   = 1'b0;
            state_nxt = ES_FIN;
          end else if (leaf_hit) begin
            cur_node_nxt = '0;
            chk_nxt      = 1'b0;
            if (rem_r != '0) begin
              mem_re    = 1'b1;
              mem_raddr = '0;
            end
          end else begin
            rem_nxt = rem_m1;
            if (dec_next == '0) begin
              padding_nxt = 1'b1;
              chk_nxt     = 1'b0;
            end else begin
              cur_node_nxt = dec_next;
              mem_re       = 1'b1;
              mem_raddr    = dec_next;
              chk_nxt      = 1'b1;
            end
          end
        end
      end

      ES_FIN: begin
        if (pend_v_r) begin
          if (res_ready) begin
            res_push   = 1'b1;
            res.last   = 1'b1;
            pend_v_nxt = 1'b0;
            state_nxt  = ES_IDLE;
          end
        end else begin
          state_nxt = ES_IDLE;
        end
      end

      default: begin
        state_nxt = ES_IDLE;
      end
    endcase

    // one result is held back so the last one of an item can be marked
    if (res_new && go) begin
      if (pend_v_r) begin
        res_push = 1'b1;
      end
      pend_nxt   = new_res;
      pend_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ES_IDLE;
      used_r      <= NODE_CW'(1);
      cur_node_r  <= '0;
      padding_r   <= 1'b0;
      error_r     <= 1'b0;
      chk_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      rd_root_r   <= 1'b0;
      root_init_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      used_r     <= used_nxt;
      cur_node_r <= cur_node_nxt;
      padding_r  <= padding_nxt;
      error_r    <= error_nxt;
      chk_r      <= chk_nxt;
      pend_v_r   <= pend_v_nxt;
      if (mem_re) begin
        rd_root_r <= (mem_raddr == '0);
      end
      if (mem_we && mem_waddr == '0) begin
        root_init_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    sym_r      <= sym_nxt;
    code_r     <= code_nxt;
    byte_r     <= byte_nxt;
    eos_r      <= eos_nxt;
    rem_r      <= rem_nxt;
    ins_node_r <= ins_node_nxt;
    fresh_r    <= fresh_nxt;
    pend_r     <= pend_nxt;
  end

endmodule

@@ hdl/huffman_tree_bit_decoder.sv @@
// Huffman tree bit decoder: code tree in one node RAM, walked one bit at a time.
// Insert walks the code bits, then gives its result; a bad length skips the walk.
// Decode gives one result per symbol found, plus a string-end result if the byte
// ends a string; a byte that starts in padding check only checks the padding.
// One request at a time. Each tree step is one registered RAM read.
// Sync active-low reset empties the tree and decode position; RAM is not cleared.
module huffman_tree_bit_decoder import htd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  htd_in_if.sink   in_chan,
  htd_out_if.source out_chan
);

  logic               res_ready;
  logic               res_push;
  res_t               res;
  res_t               out_res;
  logic               mem_we;
  logic [NODE_AW-1:0] mem_waddr;
  node_ent_t          mem_wdata;
  logic               mem_re;
  logic [NODE_AW-1:0] mem_raddr;
  node_ent_t          mem_rdata;

  htd_engine u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_chan.valid),
    .in_ready         (in_chan.ready),
    .in_func          (in_chan.func),
    .in_symbol        (in_chan.symbol),
    .in_code_bits     (in_chan.code_bits),
    .in_code_length   (in_chan.code_length),
    .in_data_byte     (in_chan.data_byte),
    .in_end_of_string (in_chan.end_of_string),
    .res_ready        (res_ready),
    .res_push         (res_push),
    .res              (res),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_re           (mem_re),
    .mem_raddr        (mem_raddr),
    .mem_rdata        (mem_rdata)
  );

  htd_node_mem #(
    .DEPTH (NODE_DEPTH),
    .WIDTH (NODE_W)
  ) u_node_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  htd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .res       (res),
    .can_push  (res_ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (out_res)
  );

  assign out_chan.kind           = out_res.kind;
  assign out_chan.decoded_symbol = out_res.sym;
  assign out_chan.status         = out_res.status;
  assign out_chan.last_of_run    = out_res.last;

endmodule

@@ hdl/htd_checker.sv @@
// Port-level assertions for the huffman tree bit decoder, bound to the top level.
// Depends on htd_pkg and huffman_tree_bit_decoder_defines.svh.
`include "huffman_tree_bit_decoder_defines.svh"

module htd_checker import htd_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [KIND_W-1:0]    out_kind,
  input logic [OUT_SYM_W-1:0] out_decoded_symbol,
  input logic [STAT_W-1:0]    out_status,
  input logic                 out_last_of_run
);

  `HTD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_decoded_symbol) && $stable(out_status) && $stable(out_last_of_run), "stalled result changed")
  `HTD_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "request taken while busy")
  `HTD_ASSERT_IMP(a_status_last, out_valid && (out_kind == KIND_INSERT || out_kind == KIND_STR_END), out_last_of_run && out_decoded_symbol == '0, "status result not last or has symbol")
  `HTD_ASSERT_IMP(a_symbol_ok, out_valid && out_kind == KIND_SYMBOL, out_status == STAT_OK, "symbol result with status")

endmodule

bind huffman_tree_bit_decoder htd_checker u_htd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_chan.valid),
  .in_ready           (in_chan.ready),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .out_kind           (out_chan.kind),
  .out_decoded_symbol (out_chan.decoded_symbol),
  .out_status         (out_chan.status),
  .out_last_of_run    (out_chan.last_of_run)
);
